FILE: design/url_percent_decoder_defines.svh
// Assertion macros used by the checker of the URL decoder.
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define URLD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("url decoder check failed");

// Check a condition in the cycle after its trigger.
`define URLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("url decoder check failed");

`endif

FILE: design/urldec_pkg.sv
`timescale 1ns / 1ps

package urldec_pkg;

  localparam int COUNT_BITS = 16;
  localparam int LIMIT_W    = 16;
  localparam int CMP_W      = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam int MAX_RES    = 3;

  localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((33'd1 << COUNT_BITS) - 33'd1);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(255);

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_PCT   = 2'd1;
  localparam logic [1:0] PEND_DIGIT = 2'd2;

  typedef struct packed {
    logic [7:0] in_char;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       truncated;
  } out_item_t;

  typedef struct packed {
    logic [1:0]            pending_len;
    logic [7:0]            held_digit;
    logic [COUNT_BITS-1:0] emitted_count;
    logic                  cut_flag;
  } dec_state_t;

  // Results of one character, drained one per cycle while the output is not stalled.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [1:0]              cnt;
    logic                    bare;
    logic                    fin;
    logic                    trunc;
  } res_group_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= 8'h61) ? c - 8'h20 : c;
    if (u >= 8'h41) begin
      return 4'(u - 8'h37);
    end
    return 4'(u - 8'h30);
  endfunction

endpackage

FILE: design/urldec_step.sv
`timescale 1ns / 1ps

module urldec_step
  import urldec_pkg::*;
(
  input  in_item_t            item,
  input  dec_state_t          cur,
  input  logic [LIMIT_W-1:0]  limit,
  output dec_state_t          state_next,
  output res_group_t          grp,
  output logic                grp_load
);

  logic [7:0]       c;
  logic             c_hex;
  logic             plain_emit;
  logic [7:0]       plain_byte;
  logic             plain_pend;
  logic [7:0]       cand [MAX_RES];
  logic [1:0]       ncand;
  logic [1:0]       pend_new;
  logic [7:0]       held_new;
  logic [CMP_W-1:0] eff_limit;
  logic [CMP_W-1:0] room;
  logic [1:0]       m;
  logic             cut_new;

  always_comb begin
    c          = item.in_char;
    c_hex      = is_hex(c);
    plain_emit = (c != CHAR_PCT);
    plain_byte = (c == CHAR_PLUS) ? CHAR_SPACE : c;
    plain_pend = (c == CHAR_PCT);

    for (int i = 0; i < MAX_RES; i++) begin
      cand[i] = 8'h00;
    end
    ncand    = 2'd0;
    pend_new = PEND_NONE;
    held_new = cur.held_digit;

    // Decode a completed escape; give back a broken escape literally, then take the character afresh.
    unique case (cur.pending_len)
      PEND_PCT: begin
        if (c_hex) begin
          pend_new = PEND_DIGIT;
          held_new = c;
        end else begin
          cand[0] = CHAR_PCT;
          ncand   = 2'd1;
          if (plain_emit) begin
            cand[1] = plain_byte;
            ncand   = 2'd2;
          end
          pend_new = plain_pend ? PEND_PCT : PEND_NONE;
        end
      end
      PEND_DIGIT: begin
        if (c_hex) begin
          cand[0] = {hex_value(cur.held_digit), hex_value(c)};
          ncand   = 2'd1;
        end else begin
          cand[0] = CHAR_PCT;
          cand[1] = cur.held_digit;
          ncand   = 2'd2;
          if (plain_emit) begin
            cand[2] = plain_byte;
            ncand   = 2'd3;
          end
          pend_new = plain_pend ? PEND_PCT : PEND_NONE;
        end
      end
      default: begin
        if (plain_emit) begin
          cand[0] = plain_byte;
          ncand   = 2'd1;
        end
        pend_new = plain_pend ? PEND_PCT : PEND_NONE;
      end
    endcase

    // Flush an escape left open at the end of the string.
    if (item.is_last) begin
      if (pend_new == PEND_PCT) begin
        cand[ncand] = CHAR_PCT;
        ncand       = ncand + 2'd1;
      end else if (pend_new == PEND_DIGIT) begin
        cand[0] = CHAR_PCT;
        cand[1] = held_new;
        ncand   = 2'd2;
      end
    end

    eff_limit = (CMP_W'(limit) < COUNT_MAX) ? CMP_W'(limit) : COUNT_MAX;
    // No room once the count has reached a limit that was lowered mid-string.
    room      = (CMP_W'(cur.emitted_count) >= eff_limit) ? '0 :
                eff_limit - CMP_W'(cur.emitted_count);
    m         = (room >= CMP_W'(ncand)) ? ncand : room[1:0];
    cut_new   = cur.cut_flag | (m != ncand);

    grp.bytes[0] = cand[0];
    grp.bytes[1] = cand[1];
    grp.bytes[2] = cand[2];
    grp.cnt      = (m == 2'd0) ? 2'd1 : m;
    grp.bare     = (m == 2'd0);
    grp.fin      = item.is_last;
    grp.trunc    = cut_new;
    grp_load     = (m != 2'd0) || item.is_last;

    if (item.is_last) begin
      state_next = '0;
    end else begin
      state_next.pending_len   = pend_new;
      state_next.held_digit    = held_new;
      state_next.emitted_count = cur.emitted_count + COUNT_BITS'(m);
      state_next.cut_flag      = cut_new;
    end
  end

endmodule

FILE: design/urldec_outq.sv
`timescale 1ns / 1ps

module urldec_outq
  import urldec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  res_group_t grp_in,
  input  logic       out_stall,
  output logic       out_valid,
  output out_item_t  out_data,
  output logic       drain_done
);

  res_group_t grp;
  logic [1:0] idx;
  logic       at_end;

  assign at_end     = (idx == grp.cnt - 2'd1);
  assign drain_done = out_valid && !out_stall && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (out_valid && !out_stall) begin
      if (at_end) begin
        out_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

  always_comb begin
    out_data.out_byte   = grp.bare ? 8'h00 : grp.bytes[idx];
    out_data.byte_valid = !grp.bare;
    out_data.last       = grp.fin && at_end;
    out_data.truncated  = grp.fin && at_end && grp.trunc;
  end

endmodule

FILE: design/url_percent_decoder.sv
`timescale 1ns / 1ps
// Latency: first result of an item is shown the cycle after it is accepted.
// Throughput: one item per cycle while each item yields at most one result
// and the output is not stalled; an item with more results holds the output
// group register and the input stalls until its last result is taken.
// Reset (rst, synchronous): discards any open escape, clears counts, limit 255.

module url_percent_decoder
  import urldec_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_write,
  input  logic [LIMIT_W-1:0] cfg_data
);

  dec_state_t         state;
  dec_state_t         state_next;
  logic [LIMIT_W-1:0] limit;
  res_group_t         grp;
  logic               grp_load;
  logic               drain_done;
  logic               accept;

  assign in_stall = out_valid && !drain_done;
  assign accept   = in_valid && !in_stall;

  urldec_step u_step (
    .item       (in_data),
    .cur        (state),
    .limit      (limit),
    .state_next (state_next),
    .grp        (grp),
    .grp_load   (grp_load)
  );

  urldec_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && grp_load),
    .grp_in     (grp),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .drain_done (drain_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      limit <= LIMIT_RESET;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (cfg_write) begin
        limit <= cfg_data;
      end
    end
  end

endmodule

FILE: design/urldec_checker.sv
`timescale 1ns / 1ps
`include "url_percent_decoder_defines.svh"

module urldec_checker
  import urldec_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  `URLD_ASSERT_NEXT(a_hold_valid, clk, rst, out_valid && out_stall, out_valid)
  `URLD_ASSERT_NEXT(a_hold_data, clk, rst, out_valid && out_stall, $stable(out_data))
  `URLD_ASSERT_NOW(a_bare_last, clk, rst, out_valid && !out_data.byte_valid, out_data.last)
  `URLD_ASSERT_NOW(a_bare_zero, clk, rst, out_valid && !out_data.byte_valid, out_data.out_byte == 8'h00)
  `URLD_ASSERT_NOW(a_trunc_last, clk, rst, out_valid && out_data.truncated, out_data.last)

endmodule

bind url_percent_decoder urldec_checker u_chk (.*);

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import urldec_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int WATCHDOG      = 4000;

  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_UA = 8'h41;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_write = 1'b0;
  logic [LIMIT_W-1:0] cfg_data = '0;

  url_percent_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Decoder state as the testbench tracks it.
  logic [1:0]            esc_state = PEND_NONE;
  logic [7:0]            held_char = '0;
  logic [COUNT_BITS-1:0] emitted   = '0;
  logic                  cut       = 1'b0;
  logic [LIMIT_W-1:0]    limit_now = LIMIT_RESET;

  out_item_t step_q[$];
  out_item_t decoded_fifo[$];

  int items_sent   = 0;
  int results_seen = 0;
  int fails        = 0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  logic hold_req   = 1'b0;
  logic hold_taken = 1'b0;
  int hold_cnt     = 0;
  int idle_cycles  = 0;

  function automatic bit hex_char(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || ((c | 8'h20) >= CH_LA && (c | 8'h20) <= CH_LF);
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    if (c <= CH_9) begin
      return 4'(c - CH_0);
    end
    return 4'((c | 8'h20) - CH_LA + 8'd10);
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    if (emitted >= limit_now || emitted >= COUNT_MAX || step_q.size() >= MAX_RES) begin
      cut = 1'b1;
    end else begin
      emitted++;
      step_q.push_back('{out_byte: b, byte_valid: 1'b1, last: 1'b0, truncated: 1'b0});
    end
  endfunction

  function automatic void take_plain(input logic [7:0] c);
    if (c == CHAR_PCT) begin
      esc_state = PEND_PCT;
    end else begin
      put_byte((c == CHAR_PLUS) ? CHAR_SPACE : c);
    end
  endfunction

  // Give back an open escape literally.
  function automatic void flush_escape();
    if (esc_state != PEND_NONE) put_byte(CHAR_PCT);
    if (esc_state == PEND_DIGIT) put_byte(held_char);
    esc_state = PEND_NONE;
  endfunction

  function automatic void decode_step(input in_item_t it);
    logic [7:0] c;
    out_item_t tail;
    c = it.in_char;
    step_q.delete();
    if (esc_state == PEND_DIGIT && hex_char(c)) begin
      put_byte({nibble(held_char), nibble(c)});
      esc_state = PEND_NONE;
    end else if (esc_state == PEND_PCT && hex_char(c)) begin
      held_char = c;
      esc_state = PEND_DIGIT;
    end else begin
      flush_escape();
      take_plain(c);
    end
    if (it.is_last) begin
      flush_escape();
      if (step_q.size() != 0) begin
        tail = step_q.pop_back();
      end else begin
        tail = '0;
      end
      tail.last = 1'b1;
      tail.truncated = cut;
      step_q.push_back(tail);
      held_char = '0;
      emitted = '0;
      cut = 1'b0;
    end
  endfunction

  typedef struct packed {
    logic [LIMIT_W-1:0]      new_limit;
    in_item_t                item;
    logic                    typed;
    logic [1:0]              n_typed;
    out_item_t [MAX_RES-1:0] want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic out_item_t data_out(input logic [7:0] b);
    return '{out_byte: b, byte_valid: 1'b1, last: 1'b0, truncated: 1'b0};
  endfunction

  function automatic out_item_t end_out(input logic [7:0] b, input logic v, input logic t);
    return '{out_byte: b, byte_valid: v, last: 1'b1, truncated: t};
  endfunction

  // A limit of zero keeps the current setting; n below zero leaves it to the predictor.
  function automatic dir_row_t row(input logic [LIMIT_W-1:0] lim, input logic [7:0] ch,
                                   input logic fin, input int n = -1,
                                   input out_item_t w0 = '0, input out_item_t w1 = '0,
                                   input out_item_t w2 = '0);
    dir_row_t r;
    r.new_limit = lim;
    r.item      = '{in_char: ch, is_last: fin};
    r.typed     = (n >= 0);
    r.n_typed   = 2'(n);
    r.want      = {w2, w1, w0};
    return r;
  endfunction

  function automatic in_item_t ch_item(input logic [7:0] c);
    return '{in_char: c, is_last: 1'b0};
  endfunction

  function automatic logic [7:0] rand_hex();
    logic [3:0] v;
    v = 4'($urandom_range(15));
    if (v < 4'd10) begin
      return CH_0 + 8'(v);
    end
    return (CH_UA + 8'(v) - 8'd10) | ($urandom_range(1) ? 8'h20 : 8'h00);
  endfunction

  function automatic logic [7:0] rand_nonhex();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (hex_char(c));
    return c;
  endfunction

  // Escapes, plus signs and plain text, with broken escapes mixed in.
  function automatic void build_string(ref in_item_t s[$]);
    int tokens;
    s.delete();
    tokens = $urandom_range(1, 6);
    repeat (tokens) begin
      case ($urandom_range(9))
        0, 1, 2: s.push_back(ch_item(8'($urandom_range(1, 255))));
        3: s.push_back(ch_item(CHAR_PLUS));
        4, 5, 6: begin
          s.push_back(ch_item(CHAR_PCT));
          s.push_back(ch_item(rand_hex()));
          s.push_back(ch_item(rand_hex()));
        end
        7: begin
          s.push_back(ch_item(CHAR_PCT));
          s.push_back(ch_item(rand_nonhex()));
        end
        8: begin
          s.push_back(ch_item(CHAR_PCT));
          s.push_back(ch_item(rand_hex()));
          s.push_back(ch_item(rand_nonhex()));
        end
        default: s.push_back(ch_item(CHAR_PCT));
      endcase
    end
    s[s.size() - 1].is_last = 1'b1;
  endfunction

  task automatic offer(input in_item_t it, input bit typed = 1'b0);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    decode_step(it);
    if (!typed) begin
      foreach (step_q[k]) decoded_fifo.push_back(step_q[k]);
    end
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    in_valid <= 1'b0;
    while (decoded_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    limit_now = v;
  endtask

  task automatic run_strings(input int n_items);
    in_item_t str_q[$];
    int start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      build_string(str_q);
      foreach (str_q[i]) offer(str_q[i]);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cnt   <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (decoded_fifo.size() == 0) begin
          $error("unexpected item: out_byte %0h last %0b", out_data.out_byte, out_data.last);
          fails++;
        end else begin
          want = decoded_fifo.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_data.out_byte);
            fails++;
          end
          if (out_data.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, out_data.byte_valid);
            fails++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data.last);
            fails++;
          end
          if (out_data.truncated !== want.truncated) begin
            $error("truncated: expected %0b, got %0b", want.truncated, out_data.truncated);
            fails++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [LIMIT_W-1:0] small_lim_a;
    logic [LIMIT_W-1:0] small_lim_c;

    // Reset limit of 255 first, then limits of one and two for truncation.
    dir_rows.push_back(row(0, "a", 0, 1, data_out("a")));
    dir_rows.push_back(row(0, CHAR_PLUS, 0, 1, data_out(CHAR_SPACE)));
    dir_rows.push_back(row(0, CHAR_PCT, 0, 0));
    dir_rows.push_back(row(0, "f", 0, 0));
    dir_rows.push_back(row(0, "F", 0, 1, data_out(8'hFF)));
    dir_rows.push_back(row(0, CHAR_PCT, 0, 0));
    dir_rows.push_back(row(0, "0", 0, 0));
    dir_rows.push_back(row(0, "0", 0, 1, data_out(8'h00)));
    dir_rows.push_back(row(0, 8'hFF, 0, 1, data_out(8'hFF)));
    dir_rows.push_back(row(0, 8'h01, 0, 1, data_out(8'h01)));
    dir_rows.push_back(row(0, CHAR_PCT, 0));
    dir_rows.push_back(row(0, "G", 0));
    dir_rows.push_back(row(0, CHAR_PCT, 0));
    dir_rows.push_back(row(0, "4", 0));
    dir_rows.push_back(row(0, "z", 0));
    dir_rows.push_back(row(0, CHAR_PCT, 0));
    dir_rows.push_back(row(0, "b", 0));
    dir_rows.push_back(row(0, CHAR_PLUS, 1));
    // Escape cut short by the end of the string.
    dir_rows.push_back(row(0, CHAR_PCT, 1, 1, end_out(CHAR_PCT, 1, 0)));
    dir_rows.push_back(row(1, "a", 0, 1, data_out("a")));
    dir_rows.push_back(row(0, "b", 1, 1, end_out(8'h00, 0, 1)));
    dir_rows.push_back(row(0, CHAR_PCT, 0));
    dir_rows.push_back(row(0, "7", 1));
    // Exactly at the limit: not truncated.
    dir_rows.push_back(row(2, "p", 0, 1, data_out("p")));
    dir_rows.push_back(row(0, "q", 1, 1, end_out("q", 1, 0)));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].new_limit != 0) write_limit(dir_rows[i].new_limit);
      offer(dir_rows[i].item, dir_rows[i].typed);
      if (dir_rows[i].typed) begin
        for (int k = 0; k < dir_rows[i].n_typed; k++) decoded_fifo.push_back(dir_rows[i].want[k]);
      end
    end

    small_lim_a = LIMIT_W'($urandom_range(2, 6));
    write_limit(small_lim_a);
    tx_idle_pct <= 30;
    rx_idle_pct <= 84;
    run_strings(25);

    write_limit(16'hFFFF);
    tx_idle_pct <= 84;
    rx_idle_pct <= 30;
    run_strings(25);

    // Keep offering while the receiver holds off so the input backs up.
    small_lim_c = LIMIT_W'($urandom_range(1, 12));
    write_limit(small_lim_c);
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    hold_req    <= 1'b1;
    run_strings(25);

    in_valid <= 1'b0;
    while (decoded_fifo.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    foreach (decoded_fifo[i]) begin
      $error("out_byte: expected %0h, got nothing", decoded_fifo[i].out_byte);
    end
    $display("Sent %0d characters, checked %0d output items", items_sent, results_seen);
    $display("Limits used: 255, 1, 2, %0d, 65535, %0d; escapes, plus signs, truncation",
             small_lim_a, small_lim_c);
    if (fails == 0 && decoded_fifo.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/urldec_pkg.sv
design/urldec_step.sv
design/urldec_outq.sv
design/url_percent_decoder.sv
design/urldec_checker.sv
dv/testbench.sv
